[hdl/ifd_pkg.sv]
`default_nettype none

package ifd_pkg;

    localparam logic [2:0] V_DROP          = 3'd0;
    localparam logic [2:0] V_ECHO          = 3'd1;
    localparam logic [2:0] V_PORT_UNREACH  = 3'd2;
    localparam logic [2:0] V_TIME_EXCEEDED = 3'd3;
    localparam logic [2:0] V_FORWARD       = 3'd4;
    localparam logic [2:0] V_NET_UNREACH   = 3'd5;
    localparam logic [2:0] V_WRITTEN       = 3'd6;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic       REQ_WRITE    = 1'b0;

    localparam logic [2:0] CFG_IFACE_COUNT  = 3'd0;
    localparam logic [2:0] CFG_IFACE_ADDR_0 = 3'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_DONE,
        OP_LOOKUP
    } t_op_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_FIN
    } t_bstate;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } t_route;

    typedef struct packed {
        t_op_kind    kind;
        logic [2:0]  verdict;
        logic [3:0]  index;
        t_route      route;
        logic        entry_valid;
        logic [31:0] dest;
        logic [7:0]  ttl;
    } t_op;

endpackage

`default_nettype wire

[hdl/ifd_front.sv]
`default_nettype none

module ifd_front #(
    parameter int NUM_IFACES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_req_type,
    input  wire logic [3:0]        i_entry_index,
    input  wire logic [31:0]       i_entry_prefix,
    input  wire logic [31:0]       i_entry_mask,
    input  wire logic [31:0]       i_entry_gateway,
    input  wire logic [1:0]        i_entry_port,
    input  wire logic              i_entry_valid,
    input  wire logic [31:0]       i_dest_addr,
    input  wire logic [7:0]        i_ttl,
    input  wire logic [7:0]        i_protocol,
    input  wire logic              i_header_ok,
    output ifd_pkg::t_op           o_op
);

    logic [2:0]  r_iface_count;
    logic [31:0] r_iface_addr [NUM_IFACES];
    logic [2:0]  clip_count;
    logic        is_local;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_count <= 3'd0;
            for (int k = 0; k < NUM_IFACES; k++) begin
                r_iface_addr[k] <= 32'd0;
            end
        end else if (i_cfg_wr) begin
            if (i_cfg_idx == ifd_pkg::CFG_IFACE_COUNT) begin
                r_iface_count <= i_cfg_data[2:0];
            end
            for (int k = 0; k < NUM_IFACES; k++) begin
                if (i_cfg_idx == ifd_pkg::CFG_IFACE_ADDR_0 + 3'(k)) begin
                    r_iface_addr[k] <= i_cfg_data;
                end
            end
        end
    end

    // counts above the number of interfaces act as that number
    always_comb begin
        clip_count = (r_iface_count > 3'(NUM_IFACES)) ? 3'(NUM_IFACES) : r_iface_count;
        is_local = 1'b0;
        for (int k = 0; k < NUM_IFACES; k++) begin
            if ((3'(k) < clip_count) && (r_iface_addr[k] == i_dest_addr)) begin
                is_local = 1'b1;
            end
        end
    end

    always_comb begin
        o_op.index         = i_entry_index;
        o_op.route.prefix  = i_entry_prefix;
        o_op.route.mask    = i_entry_mask;
        o_op.route.gateway = i_entry_gateway;
        o_op.route.port    = i_entry_port;
        o_op.entry_valid   = i_entry_valid;
        o_op.dest          = i_dest_addr;
        o_op.ttl           = i_ttl;
        priority if (i_req_type == ifd_pkg::REQ_WRITE) begin
            o_op.kind    = ifd_pkg::OP_WRITE;
            o_op.verdict = ifd_pkg::V_WRITTEN;
        end else if (!i_header_ok) begin
            o_op.kind    = ifd_pkg::OP_DONE;
            o_op.verdict = ifd_pkg::V_DROP;
        end else if (is_local) begin
            o_op.kind    = ifd_pkg::OP_DONE;
            o_op.verdict = (i_protocol == ifd_pkg::PROTO_ICMP) ?
                           ifd_pkg::V_ECHO : ifd_pkg::V_PORT_UNREACH;
        end else if (i_ttl <= 8'd1) begin
            o_op.kind    = ifd_pkg::OP_DONE;
            o_op.verdict = ifd_pkg::V_TIME_EXCEEDED;
        end else begin
            o_op.kind    = ifd_pkg::OP_LOOKUP;
            o_op.verdict = ifd_pkg::V_NET_UNREACH;
        end
    end

endmodule

`default_nettype wire

[hdl/ifd_queue.sv]
`default_nettype none

module ifd_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire ifd_pkg::t_op i_op,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output ifd_pkg::t_op      o_op
);

    localparam int PTR_W = $clog2(ifd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ifd_pkg::QUEUE_DEPTH + 1);

    ifd_pkg::t_op       r_slot [ifd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(ifd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

[hdl/ifd_back.sv]
`default_nettype none

module ifd_back #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire ifd_pkg::t_op i_q_op,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [2:0]        o_verdict,
    output logic [31:0]       o_next_hop,
    output logic [1:0]        o_out_port,
    output logic [7:0]        o_new_ttl
);

    localparam int              IDX_W     = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);
    localparam logic [8:0]      N_ENTRIES = 9'(ROUTE_ENTRIES);

    ifd_pkg::t_bstate     r_state;
    ifd_pkg::t_bstate     n_state;

    ifd_pkg::t_route      r_mem [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] r_valid;
    ifd_pkg::t_route      r_rd_data;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [IDX_W-1:0]     r_scan_idx;

    logic [31:0]          r_dest;
    logic [7:0]           r_ttl;
    logic                 r_found;
    logic [31:0]          r_best_mask;
    logic [31:0]          r_best_gw;
    logic [1:0]           r_best_port;

    logic                 r_out_vld;
    logic [2:0]           r_out_verdict;
    logic [31:0]          r_out_next_hop;
    logic [1:0]           r_out_port;
    logic [7:0]           r_out_ttl;

    logic                 out_free;
    logic                 pop;
    logic                 start_scan;
    logic                 load_out;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic                 hit;
    logic [2:0]           res_verdict;
    logic [31:0]          res_next_hop;
    logic [1:0]           res_port;
    logic [7:0]           res_ttl;

    assign out_free = !r_out_vld || !i_out_stall;
    assign wr_addr  = IDX_W'(i_q_op.index);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifd_pkg::B_IDLE: begin
                if (i_q_valid && out_free && (i_q_op.kind == ifd_pkg::OP_LOOKUP)) begin
                    n_state = ifd_pkg::B_SCAN;
                end
            end
            ifd_pkg::B_SCAN: begin
                if (r_scan_idx == LAST_IDX) begin
                    n_state = ifd_pkg::B_DRAIN;
                end
            end
            ifd_pkg::B_DRAIN: begin
                n_state = ifd_pkg::B_FIN;
            end
            ifd_pkg::B_FIN: begin
                if (out_free) begin
                    n_state = ifd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = ifd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        pop          = 1'b0;
        start_scan   = 1'b0;
        load_out     = 1'b0;
        mem_we       = 1'b0;
        res_verdict  = i_q_op.verdict;
        res_next_hop = 32'd0;
        res_port     = 2'd0;
        res_ttl      = i_q_op.ttl;
        unique case (r_state)
            ifd_pkg::B_IDLE: begin
                pop = i_q_valid && out_free;
                unique case (i_q_op.kind)
                    ifd_pkg::OP_WRITE: begin
                        load_out = pop;
                        mem_we   = pop && ({5'd0, i_q_op.index} < N_ENTRIES);
                    end
                    ifd_pkg::OP_DONE: begin
                        load_out = pop;
                    end
                    ifd_pkg::OP_LOOKUP: begin
                        start_scan = pop;
                    end
                    default: begin
                        load_out = pop;
                    end
                endcase
            end
            ifd_pkg::B_FIN: begin
                load_out = out_free;
                if (r_found) begin
                    res_verdict  = ifd_pkg::V_FORWARD;
                    res_next_hop = r_best_gw;
                    res_port     = r_best_port;
                    res_ttl      = r_ttl - 8'd1;
                end else begin
                    res_verdict  = ifd_pkg::V_NET_UNREACH;
                    res_ttl      = r_ttl;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pop = pop;

    // route match on the entry read in the previous cycle
    assign hit = r_rd_vld && r_valid[r_rd_idx]
              && (((r_dest ^ r_rd_data.prefix) & r_rd_data.mask) == 32'd0)
              && (!r_found || (r_best_mask < r_rd_data.mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ifd_pkg::B_IDLE;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ifd_pkg::B_SCAN);
            if (mem_we) begin
                r_valid[wr_addr] <= i_q_op.entry_valid;
            end
            if (start_scan) begin
                r_found <= 1'b0;
            end else if (hit) begin
                r_found <= 1'b1;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_q_op.route;
        end
        if (r_state == ifd_pkg::B_SCAN) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_idx;
        if (start_scan) begin
            r_scan_idx <= '0;
            r_dest     <= i_q_op.dest;
            r_ttl      <= i_q_op.ttl;
        end else if ((r_state == ifd_pkg::B_SCAN) && (r_scan_idx != LAST_IDX)) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (hit) begin
            r_best_mask <= r_rd_data.mask;
            r_best_gw   <= r_rd_data.gateway;
            r_best_port <= r_rd_data.port;
        end
        if (load_out) begin
            r_out_verdict  <= res_verdict;
            r_out_next_hop <= res_next_hop;
            r_out_port     <= res_port;
            r_out_ttl      <= res_ttl;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_verdict   = r_out_verdict;
    assign o_next_hop  = r_out_next_hop;
    assign o_out_port  = r_out_port;
    assign o_new_ttl   = r_out_ttl;

endmodule

`default_nettype wire

[hdl/ipv4_forward_decision.sv]
`default_nettype none

// channel   valid         stall         payload
// in        i_in_valid    o_in_stall    i_req_type .. i_header_ok
// out       o_out_valid   i_out_stall   o_verdict, o_next_hop, o_out_port, o_new_ttl
// config    i_cfg_wr      -             i_cfg_idx, i_cfg_data
//
// table writes and packets settled by the classifier load the output register directly;
// a route lookup walks the table one entry per cycle through the single read port
// of the route memory; the back end pops no new item until the lookup is done.
// a two-deep queue lets the classifier take items while the back end is busy.
// synchronous active-low reset clears control state and the route valid bits.

module ipv4_forward_decision #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int NUM_IFACES    = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic [31:0] i_entry_prefix,
    input  wire logic [31:0] i_entry_mask,
    input  wire logic [31:0] i_entry_gateway,
    input  wire logic [1:0]  i_entry_port,
    input  wire logic        i_entry_valid,
    input  wire logic [31:0] i_dest_addr,
    input  wire logic [7:0]  i_ttl,
    input  wire logic [7:0]  i_protocol,
    input  wire logic        i_header_ok,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_verdict,
    output logic [31:0]      o_next_hop,
    output logic [1:0]       o_out_port,
    output logic [7:0]       o_new_ttl
);

    ifd_pkg::t_op front_op;
    ifd_pkg::t_op head_op;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;

    assign o_in_stall = q_full;

    ifd_front #(
        .NUM_IFACES (NUM_IFACES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_wr),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_prefix  (i_entry_prefix),
        .i_entry_mask    (i_entry_mask),
        .i_entry_gateway (i_entry_gateway),
        .i_entry_port    (i_entry_port),
        .i_entry_valid   (i_entry_valid),
        .i_dest_addr     (i_dest_addr),
        .i_ttl           (i_ttl),
        .i_protocol      (i_protocol),
        .i_header_ok     (i_header_ok),
        .o_op            (front_op)
    );

    ifd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    ifd_back #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (head_op),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (o_verdict),
        .o_next_hop  (o_next_hop),
        .o_out_port  (o_out_port),
        .o_new_ttl   (o_new_ttl)
    );

endmodule

`default_nettype wire
